/* rtl/eapol_key_message_classifier_macros.svh */
// Assertion macros for the EAPOL-Key message classifier.
`ifndef EAPOL_KEY_MESSAGE_CLASSIFIER_MACROS_SVH
`define EAPOL_KEY_MESSAGE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define EKMC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ekmc assertion failed");
// Checked at every edge, reset included.
`define EKMC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("ekmc assertion failed");
`else
`define EKMC_ASSERT(label, prop)
`define EKMC_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* rtl/ekmc_pkg.sv */
package ekmc_pkg;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] C_BASE_HDR_LEN = 6'd24;
    localparam logic [POS_W-1:0] C_QOS_EXTRA    = 6'd2;
    localparam logic [POS_W-1:0] C_POS_MAX      = 6'd63;
    localparam logic [POS_W-1:0] C_SNAP_LEN     = 6'd8;
    localparam logic [POS_W-1:0] C_OFF_TYPE     = 6'd9;
    localparam logic [POS_W-1:0] C_OFF_KI_HI    = 6'd13;
    localparam logic [POS_W-1:0] C_OFF_KI_LO    = 6'd14;

    localparam logic [3:0] C_QOS_NIBBLE  = 4'h8;
    localparam logic [1:0] C_TYPE_DATA   = 2'b10;
    localparam logic [7:0] C_EAPOL_KEY   = 8'h03;

    typedef enum logic [2:0] {
        MSG_NONE = 3'd0,
        MSG_1    = 3'd1,
        MSG_2    = 3'd2,
        MSG_3    = 3'd3,
        MSG_4    = 3'd4
    } t_msg_class;

    // One accepted frame byte.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_byte_req;

    // LLC/SNAP header expected right after the MAC header.
    function automatic logic [7:0] snap_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'hAA;
            3'd1:    v = 8'hAA;
            3'd2:    v = 8'h03;
            3'd6:    v = 8'h88;
            3'd7:    v = 8'h8E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_msg_class classify(input logic [15:0] ki);
        logic install;
        logic ack;
        logic mic;
        logic secure;
        t_msg_class c;
        install = ki[6];
        ack     = ki[7];
        mic     = ki[8];
        secure  = ki[9];
        if (ack && !mic && !install) begin
            c = MSG_1;
        end else if (!ack && mic && !install && !secure) begin
            c = MSG_2;
        end else if (ack && mic && install) begin
            c = MSG_3;
        end else if (!ack && mic && !install && secure) begin
            c = MSG_4;
        end else begin
            c = MSG_NONE;
        end
        return c;
    endfunction

endpackage

/* rtl/eapol_key_message_classifier.sv */
// EAPOL-Key message classifier: takes an 802.11 frame one byte per request,
// starting at the frame control byte, and gives one result per frame on the
// byte marked last: 1 to 4 for the four-way handshake message number, or 0
// when the frame is not a data frame carrying a matching LLC/SNAP + EAPOL-Key
// header, ends before the Key Information word or has flags matching no
// message. A byte is taken in every cycle; the last byte passes one input
// register, then combinational parsing straight into the result register.
// The only back pressure is a result still waiting in the result register
// when the next frame's last byte reaches the parse stage.
`include "eapol_key_message_classifier_macros.svh"

module eapol_key_message_classifier
    import ekmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_frame_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_message_class
);

    t_byte_req  in_req;
    t_byte_req  stg_req;
    logic       stg_valid;
    logic       advance;
    t_msg_class parse_class;

    logic       r_out_valid;
    logic       n_out_valid;
    t_msg_class r_out_class;

    assign in_req.frame_byte = i_frame_byte;
    assign in_req.last_byte  = i_last_byte;

    // hold a last byte while the previous result is still waiting
    assign advance = stg_valid
        && !(stg_req.last_byte && r_out_valid && !i_out_ready);

    ekmc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_req     (in_req),
        .o_ready   (o_in_ready),
        .i_advance (advance),
        .o_valid   (stg_valid),
        .o_req     (stg_req)
    );

    ekmc_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (stg_req),
        .o_class   (parse_class)
    );

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (advance && stg_req.last_byte) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && stg_req.last_byte) begin
            r_out_class <= parse_class;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_message_class = r_out_class;

    `EKMC_ASSERT(a_last_gives_result, advance && stg_req.last_byte |=> r_out_valid)
    `EKMC_ASSERT(a_class_range, r_out_valid |-> r_out_class <= MSG_4)
    `EKMC_ASSERT_ALWAYS(a_ready_when_empty, !stg_valid |-> o_in_ready)

endmodule

/* rtl/ekmc_in_stage.sv */
module ekmc_in_stage
    import ekmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_byte_req i_req,
    output logic      o_ready,
    input  logic      i_advance,
    output logic      o_valid,
    output t_byte_req o_req
);

    logic      r_valid;
    logic      n_valid;
    t_byte_req r_req;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

/* rtl/ekmc_parse.sv */
module ekmc_parse
    import ekmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_byte_req  i_req,
    output t_msg_class o_class
);

    logic [POS_W-1:0] r_pos;
    logic             r_is_qos;
    logic             r_match;
    logic [15:0]      r_key_info;

    logic [POS_W-1:0] n_pos;
    logic             n_is_qos;
    logic             n_match;
    logic [15:0]      n_key_info;

    logic [POS_W-1:0] hdr_len;
    logic [POS_W-1:0] off;
    logic             past_hdr;
    logic [7:0]       b;

    always_comb begin
        b        = i_req.frame_byte;
        n_is_qos = r_is_qos;
        n_match  = r_match;
        n_key_info = r_key_info;
        if (r_pos == '0) begin
            n_is_qos = (b[7:4] == C_QOS_NIBBLE);
            if (b[3:2] != C_TYPE_DATA) begin
                n_match = 1'b0;
            end
        end
        hdr_len  = C_BASE_HDR_LEN + (n_is_qos ? C_QOS_EXTRA : '0);
        off      = r_pos - hdr_len;
        past_hdr = (r_pos >= hdr_len);

        if (r_pos != '0 && past_hdr) begin
            if (off < C_SNAP_LEN) begin
                if (b != snap_byte(off[2:0])) begin
                    n_match = 1'b0;
                end
            end else if (off == C_OFF_TYPE) begin
                if (b != C_EAPOL_KEY) begin
                    n_match = 1'b0;
                end
            end else if (off == C_OFF_KI_HI) begin
                n_key_info = {b, r_key_info[7:0]};
            end else if (off == C_OFF_KI_LO) begin
                n_key_info = {r_key_info[15:8], b};
            end
        end

        o_class = MSG_NONE;
        if (n_match && past_hdr && off >= C_OFF_KI_LO) begin
            o_class = classify(n_key_info);
        end

        n_pos = (r_pos < C_POS_MAX) ? r_pos + 1'b1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_is_qos   <= 1'b0;
            r_match    <= 1'b1;
            r_key_info <= '0;
        end else if (i_advance) begin
            if (i_req.last_byte) begin
                // end of frame: back to the start
                r_pos      <= '0;
                r_is_qos   <= 1'b0;
                r_match    <= 1'b1;
                r_key_info <= '0;
            end else begin
                r_pos      <= n_pos;
                r_is_qos   <= n_is_qos;
                r_match    <= n_match;
                r_key_info <= n_key_info;
            end
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import ekmc_pkg::*;

    // LLC/SNAP header that must follow the MAC header, first byte on top
    localparam logic [63:0] LLC_SNAP_HDR = 64'hAAAA_0300_0000_888E;
    localparam int          SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } t_pending_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] frame_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_message_class;

    t_pending_byte byte_q[$];
    t_msg_class    class_q[$];

    // classifier state as the testbench tracks it
    int          frame_pos = 0;
    logic        qos_frame = 1'b0;
    logic        header_ok = 1'b1;
    logic [15:0] key_info_word = 16'h0000;

    int errors = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int n_bytes = 0;
    int n_frames = 0;

    eapol_key_message_classifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_frame_byte    (frame_byte),
        .i_last_byte     (last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_message_class (o_message_class)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic t_msg_class handshake_msg(input logic [15:0] ki);
        logic [3:0] flags;
        t_msg_class m;
        flags = {ki[9], ki[8], ki[7], ki[6]}; // secure, mic, ack, install
        m = MSG_NONE;
        if (flags[1] && flags[0] && flags[2]) begin
            m = MSG_3;
        end else if (flags[1] && !flags[2] && !flags[0]) begin
            m = MSG_1;
        end else if (flags[2] && !flags[1] && !flags[0]) begin
            m = flags[3] ? MSG_4 : MSG_2;
        end
        return m;
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic last);
        int hdr;
        int rel;
        if (frame_pos == 0) begin
            qos_frame = (b[7:4] == C_QOS_NIBBLE);
            if (b[3:2] != C_TYPE_DATA) header_ok = 1'b0;
        end
        hdr = int'(C_BASE_HDR_LEN) + (qos_frame ? int'(C_QOS_EXTRA) : 0);
        rel = frame_pos - hdr;
        if (frame_pos != 0) begin
            if (rel >= 0 && rel < int'(C_SNAP_LEN)) begin
                if (b != LLC_SNAP_HDR[63 - 8*rel -: 8]) header_ok = 1'b0;
            end else if (rel == int'(C_OFF_TYPE)) begin
                if (b != C_EAPOL_KEY) header_ok = 1'b0;
            end else if (rel == int'(C_OFF_KI_HI)) begin
                key_info_word[15:8] = b;
            end else if (rel == int'(C_OFF_KI_LO)) begin
                key_info_word[7:0] = b;
            end
        end
        if (last) begin
            if (header_ok && rel >= int'(C_OFF_KI_LO)) class_q.push_back(handshake_msg(key_info_word));
            else class_q.push_back(MSG_NONE);
            frame_pos = 0;
            qos_frame = 1'b0;
            header_ok = 1'b1;
            key_info_word = 16'h0000;
        end else if (frame_pos < int'(C_POS_MAX)) begin
            frame_pos++;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last, input logic drain);
        t_pending_byte req;
        req.data = b;
        req.last = last;
        req.drain = drain;
        byte_q.push_back(req);
        n_bytes++;
    endtask

    // Build one frame; corrupt_at < 0 leaves it intact, raw fills it with noise.
    task automatic queue_frame(input logic qos, input logic [15:0] ki, input int len,
                               input int corrupt_at, input logic raw, input logic drain);
        int hdr;
        int nib;
        logic [7:0] b;
        hdr = int'(C_BASE_HDR_LEN) + (qos ? int'(C_QOS_EXTRA) : 0);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (!raw) begin
                if (i == 0) begin
                    nib = $urandom_range(0, 14);
                    if (nib >= 8) nib++;
                    b[7:4] = qos ? C_QOS_NIBBLE : nib[3:0];
                    b[3:2] = C_TYPE_DATA;
                end else if (i >= hdr && i < hdr + 8) begin
                    b = LLC_SNAP_HDR[63 - 8*(i - hdr) -: 8];
                end else if (i == hdr + int'(C_OFF_TYPE)) begin
                    b = C_EAPOL_KEY;
                end else if (i == hdr + int'(C_OFF_KI_HI)) begin
                    b = ki[15:8];
                end else if (i == hdr + int'(C_OFF_KI_LO)) begin
                    b = ki[7:0];
                end
            end
            if (i == corrupt_at) b = b ^ (8'h01 << $urandom_range(0, 7));
            queue_byte(b, i == len - 1, drain && i == 0);
        end
        n_frames++;
    endtask

    // sender: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        t_pending_byte req;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            frame_byte <= 8'h00;
            last_byte <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) track_byte(frame_byte, last_byte);
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (byte_q[0].drain && class_q.size() != 0) begin
                    // hold until every pending result is out
                    in_valid <= 1'b0;
                end else begin
                    req = byte_q.pop_front();
                    in_valid <= 1'b1;
                    frame_byte <= req.data;
                    last_byte <= req.last;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver: stall pattern switches between modes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= (stall_left % 5 < 2);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_msg_class want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (class_q.size() == 0) begin
                if (errors < 10) $display("unexpected result: message_class=%0d", o_message_class);
                errors++;
            end else begin
                want = class_q.pop_front();
                if (o_message_class !== want) begin
                    if (errors < 10)
                        $display("message_class mismatch: expected %0d, got %0d",
                                 want, o_message_class);
                    errors++;
                end
            end
        end
    end

    initial begin
        int r;
        int hdr;
        logic qos;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest frames: one or two bytes, extremes of the byte
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'h88, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        // each handshake message at the shortest length that reaches key info
        queue_frame(1'b0, 16'h008A, 39, -1, 1'b0, 1'b0);
        queue_frame(1'b0, 16'h010A, 39, -1, 1'b0, 1'b0);
        queue_frame(1'b0, 16'h13CA, 39, -1, 1'b0, 1'b0);
        queue_frame(1'b0, 16'h030A, 39, -1, 1'b0, 1'b1);
        queue_frame(1'b1, 16'h13CA, 41, -1, 1'b0, 1'b0);
        // ends one byte before the low key info byte
        queue_frame(1'b0, 16'h008A, 38, -1, 1'b0, 1'b0);
        // runs past the counter limit
        queue_frame(1'b1, 16'h010A, 72, -1, 1'b0, 1'b0);

        while (n_bytes < 1450) begin
            qos = 1'($urandom_range(0, 1));
            hdr = int'(C_BASE_HDR_LEN) + (qos ? int'(C_QOS_EXTRA) : 0);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                queue_frame(qos, 16'($urandom), hdr + 15 + $urandom_range(0, 6), -1, 1'b0,
                            n_frames % 9 == 4);
            end else if (r < 72) begin
                queue_frame(qos, 16'($urandom), hdr + 15 + $urandom_range(0, 4),
                            $urandom_range(0, hdr + 9), 1'b0, 1'b0);
            end else if (r < 82) begin
                queue_frame(qos, 16'($urandom), $urandom_range(1, hdr + 15), -1, 1'b0, 1'b0);
            end else if (r < 90) begin
                queue_frame(qos, 16'($urandom), $urandom_range(hdr + 16, 80), -1, 1'b0, 1'b0);
            end else begin
                queue_frame(qos, 16'($urandom), $urandom_range(1, 50), -1, 1'b1, 1'b0);
            end
        end

        while (byte_q.size() != 0 || in_valid || class_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
